// File: hw/rtl/mcfd_pkg.sv
package mcfd_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PACKED  = 2'd0,
        ST_INT16   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_SHORT   = 2'd3
    } t_status;

    localparam int unsigned FRAC_BITS_DEFAULT = 16;

    // Identifiers and slots
    localparam logic [28:0] ID_PACKED_LO = 29'd1;
    localparam logic [28:0] ID_PACKED_HI = 29'd6;
    localparam logic [28:0] ID_SLOT6     = 29'h700;
    localparam logic [28:0] ID_SLOT7     = 29'h800;
    localparam logic [2:0]  SLOT_NONE    = 3'd0;
    localparam logic [2:0]  SLOT_SIX     = 3'd6;
    localparam logic [2:0]  SLOT_SEVEN   = 3'd7;
    localparam int unsigned N_SLOTS      = 8;
    localparam logic [3:0]  DLC_PACKED   = 4'd6;
    localparam logic [3:0]  DLC_INT16    = 4'd7;

    // Lanes: position, velocity, torque
    localparam int unsigned N_LANES   = 3;
    localparam int unsigned LANE_POS  = 0;
    localparam int unsigned LANE_VEL  = 1;
    localparam int unsigned LANE_TOR  = 2;

    // Datapath widths
    localparam int unsigned MAG_W      = 25;
    localparam int unsigned MULT_W     = 54;
    localparam int unsigned MULT_SPLIT = 27;
    localparam int unsigned PP_W       = MAG_W + MULT_SPLIT;
    localparam int unsigned SUM_W      = 88;
    localparam int unsigned Q_W        = 34;

    typedef logic [MAG_W-1:0]  t_mag;
    typedef logic [MULT_W-1:0] t_mult;
    typedef logic [PP_W-1:0]   t_pp;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [Q_W-1:0]    t_q;

    // Reciprocal shift amounts; the turn shifts are a base less FRAC_BITS
    localparam int unsigned SH_POS_PK     = 42;
    localparam int unsigned SH_SMALL_PK   = 34;
    localparam int unsigned SH_TOR_FX     = 43;
    localparam int unsigned SH_POS_TURN_B = 61;
    localparam int unsigned SH_VEL_TURN_B = 59;

    // 2*pi in Q32
    localparam logic [35:0] TWO_PI_Q32 = 36'h6487ED511;

    // Torque int16 form: (t * 4855 - 83000) / 1e6 == (t * 971 - 16600) / 2e5
    localparam logic signed [26:0] TOR_GAIN   = 27'sd971;
    localparam logic signed [26:0] TOR_OFFSET = 27'sd16600;

endpackage

// File: hw/rtl/motor_can_feedback_decoder.sv
// An accepted beat (start high, busy low) passes r_s1, r_s2, r_s3 and r_out to o_strobe.
// One beat per cycle while busy is low; the four register stages hold up to four beats.
// The receiver cannot stall: every result is shown for exactly one cycle under o_strobe.
// Reset (i_rst_n low, synchronous) drops all beats in flight and holds busy high;
// busy falls at the first edge that samples reset released and then stays low.
module motor_can_feedback_decoder #(
    parameter int unsigned FRAC_BITS = mcfd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [28:0]        i_frame_id,
    input  logic [3:0]         i_length_code,
    input  logic [7:0]         i_byte_one,
    input  logic [7:0]         i_byte_two,
    input  logic [7:0]         i_byte_three,
    input  logic [7:0]         i_byte_four,
    input  logic [7:0]         i_byte_five,
    input  logic [7:0]         i_byte_six,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic [2:0]         o_motor_slot,
    output logic signed [31:0] o_position_rad,
    output logic signed [31:0] o_velocity_rad_s,
    output logic signed [31:0] o_torque_nm
);

    // ------------------------------------------------------------------
    // Scaling constants.
    // Every field is v = P * a / b + 1/2 (P the magnitude, rounded by floor).
    // With M = ceil(a * 2^T / b) and P_max * b < 2^T, floor((P*M + 2^(T-1)) >> T)
    // is exact: the rounding error stays below the spacing 1/b of the fractions.
    // Packed slots use a = max_milli * 2^F, b = (2^bits - 1) * 1000.
    // Slots six and seven use the 2*pi Q32 ratio (position, velocity) and
    // 2^F / 200000 (torque). All divisions resolve at elaboration.
    // ------------------------------------------------------------------
    localparam logic [127:0] DEN16 = 128'd65535000;
    localparam logic [127:0] DEN12 = 128'd4095000;
    localparam logic [127:0] TWO_PI_W = 128'(mcfd_pkg::TWO_PI_Q32);

    localparam int unsigned SH_POS_FX = mcfd_pkg::SH_POS_TURN_B - FRAC_BITS;
    localparam int unsigned SH_VEL_FX = mcfd_pkg::SH_VEL_TURN_B - FRAC_BITS;

    localparam logic [127:0] POS_NUM_A =
        128'd12500 << (FRAC_BITS + mcfd_pkg::SH_POS_PK);
    localparam logic [127:0] POS_NUM_B =
        128'd12566 << (FRAC_BITS + mcfd_pkg::SH_POS_PK);
    localparam mcfd_pkg::t_mult POS_M_A =
        mcfd_pkg::t_mult'((POS_NUM_A + DEN16 - 128'd1) / DEN16);
    localparam mcfd_pkg::t_mult POS_M_B =
        mcfd_pkg::t_mult'((POS_NUM_B + DEN16 - 128'd1) / DEN16);
    localparam mcfd_pkg::t_mult POS_M_T =
        mcfd_pkg::t_mult'(((TWO_PI_W << 25) + 128'd624) / 128'd625);

    localparam int unsigned SH12 = FRAC_BITS + mcfd_pkg::SH_SMALL_PK;
    localparam mcfd_pkg::t_mult VEL_M_0 =
        mcfd_pkg::t_mult'(((128'd25000 << SH12) + DEN12 - 128'd1) / DEN12);
    localparam mcfd_pkg::t_mult VEL_M_1 =
        mcfd_pkg::t_mult'(((128'd20000 << SH12) + DEN12 - 128'd1) / DEN12);
    localparam mcfd_pkg::t_mult VEL_M_3 =
        mcfd_pkg::t_mult'(((128'd10000 << SH12) + DEN12 - 128'd1) / DEN12);
    localparam mcfd_pkg::t_mult VEL_M_5 =
        mcfd_pkg::t_mult'(((128'd30000 << SH12) + DEN12 - 128'd1) / DEN12);
    localparam mcfd_pkg::t_mult VEL_M_T =
        mcfd_pkg::t_mult'(((TWO_PI_W << 22) + 128'd124) / 128'd125);

    localparam mcfd_pkg::t_mult TOR_M_0 =
        mcfd_pkg::t_mult'(((128'd200000 << SH12) + DEN12 - 128'd1) / DEN12);
    localparam mcfd_pkg::t_mult TOR_M_1 =
        mcfd_pkg::t_mult'(((128'd120000 << SH12) + DEN12 - 128'd1) / DEN12);
    localparam mcfd_pkg::t_mult TOR_M_3 =
        mcfd_pkg::t_mult'(((128'd28000 << SH12) + DEN12 - 128'd1) / DEN12);
    localparam mcfd_pkg::t_mult TOR_M_5 =
        mcfd_pkg::t_mult'(((128'd10000 << SH12) + DEN12 - 128'd1) / DEN12);
    localparam mcfd_pkg::t_mult TOR_M_I = mcfd_pkg::t_mult'(
        ((128'd1 << (FRAC_BITS + mcfd_pkg::SH_TOR_FX)) + 128'd199999) / 128'd200000);

    // Multiplier constant per lane and slot
    localparam mcfd_pkg::t_mult M_TBL [mcfd_pkg::N_LANES][mcfd_pkg::N_SLOTS] = '{
        '{POS_M_A, POS_M_B, POS_M_B, POS_M_A, POS_M_A, POS_M_A, POS_M_T, POS_M_T},
        '{VEL_M_0, VEL_M_1, VEL_M_1, VEL_M_3, VEL_M_3, VEL_M_5, VEL_M_T, VEL_M_T},
        '{TOR_M_0, TOR_M_1, TOR_M_1, TOR_M_3, TOR_M_3, TOR_M_5, TOR_M_I, TOR_M_I}
    };

    // Result shift per lane for packed slots and for slots six and seven
    localparam int unsigned SH_PK [mcfd_pkg::N_LANES] = '{
        mcfd_pkg::SH_POS_PK, mcfd_pkg::SH_SMALL_PK, mcfd_pkg::SH_SMALL_PK
    };
    localparam int unsigned SH_FX [mcfd_pkg::N_LANES] = '{
        SH_POS_FX, SH_VEL_FX, mcfd_pkg::SH_TOR_FX
    };

    // ------------------------------------------------------------------
    // Handshake. The pipeline never stalls, so busy only covers reset.
    // ------------------------------------------------------------------
    logic r_busy;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // ------------------------------------------------------------------
    // Stage 1: classify the identifier, unpack the payload into a sign and
    // a magnitude for each lane.
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    mcfd_pkg::t_status r_s1_status, n_s1_status;
    logic [2:0]        r_s1_slot, n_s1_slot;
    logic              r_s1_neg [mcfd_pkg::N_LANES];
    logic              n_s1_neg [mcfd_pkg::N_LANES];
    mcfd_pkg::t_mag    r_s1_mag [mcfd_pkg::N_LANES];
    mcfd_pkg::t_mag    n_s1_mag [mcfd_pkg::N_LANES];

    logic              is_pk, is_fx;
    logic [15:0]       pk_pos, turn_pos, turn_vel, tor_raw;
    logic [11:0]       pk_vel, pk_tor;
    logic [16:0]       pk_pos_tw, pk_pos_mag, turn_pos_mag, turn_vel_mag;
    logic [12:0]       pk_vel_tw, pk_tor_tw, pk_vel_mag, pk_tor_mag;
    logic signed [26:0] tor_s, tor_abs;

    always_comb begin
        is_pk = (i_frame_id >= mcfd_pkg::ID_PACKED_LO) &&
                (i_frame_id <= mcfd_pkg::ID_PACKED_HI);
        is_fx = (i_frame_id == mcfd_pkg::ID_SLOT6) || (i_frame_id == mcfd_pkg::ID_SLOT7);

        // Packed: big-endian 16-bit position, then two 12-bit fields
        pk_pos = {i_byte_one, i_byte_two};
        pk_vel = {i_byte_three, i_byte_four[7:4]};
        pk_tor = {i_byte_four[3:0], i_byte_five};

        // |2x - m|, negative when x sits in the lower half
        pk_pos_tw  = {pk_pos, 1'b0};
        pk_pos_mag = pk_pos[15] ? pk_pos_tw - 17'h0FFFF : 17'h0FFFF - pk_pos_tw;
        pk_vel_tw  = {pk_vel, 1'b0};
        pk_vel_mag = pk_vel[11] ? pk_vel_tw - 13'h0FFF : 13'h0FFF - pk_vel_tw;
        pk_tor_tw  = {pk_tor, 1'b0};
        pk_tor_mag = pk_tor[11] ? pk_tor_tw - 13'h0FFF : 13'h0FFF - pk_tor_tw;

        // Little-endian int16 words
        turn_pos = {i_byte_two, i_byte_one};
        turn_vel = {i_byte_four, i_byte_three};
        tor_raw  = {i_byte_six, i_byte_five};
        turn_pos_mag = turn_pos[15] ? 17'h10000 - {1'b0, turn_pos} : {1'b0, turn_pos};
        turn_vel_mag = turn_vel[15] ? 17'h10000 - {1'b0, turn_vel} : {1'b0, turn_vel};

        tor_s   = 27'(signed'(tor_raw)) * mcfd_pkg::TOR_GAIN - mcfd_pkg::TOR_OFFSET;
        tor_abs = tor_s[26] ? -tor_s : tor_s;

        // Slot and status
        if (is_pk) begin
            n_s1_slot   = i_frame_id[2:0] - 3'd1;
            n_s1_status = (i_length_code < mcfd_pkg::DLC_PACKED) ?
                          mcfd_pkg::ST_SHORT : mcfd_pkg::ST_PACKED;
        end else if (is_fx) begin
            n_s1_slot   = (i_frame_id == mcfd_pkg::ID_SLOT6) ?
                          mcfd_pkg::SLOT_SIX : mcfd_pkg::SLOT_SEVEN;
            n_s1_status = (i_length_code < mcfd_pkg::DLC_INT16) ?
                          mcfd_pkg::ST_SHORT : mcfd_pkg::ST_INT16;
        end else begin
            n_s1_slot   = mcfd_pkg::SLOT_NONE;
            n_s1_status = mcfd_pkg::ST_UNKNOWN;
        end

        // Lane operands; junk for unknown or short frames is zeroed at the end
        if (is_fx) begin
            n_s1_neg[mcfd_pkg::LANE_POS] = turn_pos[15];
            n_s1_mag[mcfd_pkg::LANE_POS] = mcfd_pkg::t_mag'(turn_pos_mag);
            n_s1_neg[mcfd_pkg::LANE_VEL] = turn_vel[15];
            n_s1_mag[mcfd_pkg::LANE_VEL] = mcfd_pkg::t_mag'(turn_vel_mag);
            n_s1_neg[mcfd_pkg::LANE_TOR] = tor_s[26];
            n_s1_mag[mcfd_pkg::LANE_TOR] = tor_abs[mcfd_pkg::MAG_W-1:0];
        end else begin
            n_s1_neg[mcfd_pkg::LANE_POS] = !pk_pos[15];
            n_s1_mag[mcfd_pkg::LANE_POS] = mcfd_pkg::t_mag'(pk_pos_mag);
            n_s1_neg[mcfd_pkg::LANE_VEL] = !pk_vel[11];
            n_s1_mag[mcfd_pkg::LANE_VEL] = mcfd_pkg::t_mag'(pk_vel_mag);
            n_s1_neg[mcfd_pkg::LANE_TOR] = !pk_tor[11];
            n_s1_mag[mcfd_pkg::LANE_TOR] = mcfd_pkg::t_mag'(pk_tor_mag);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude times the slot constant, split into two partial
    // products on the low and high halves of the constant.
    // ------------------------------------------------------------------
    logic              r_s2_valid;
    mcfd_pkg::t_status r_s2_status;
    logic [2:0]        r_s2_slot;
    logic              r_s2_neg [mcfd_pkg::N_LANES];
    mcfd_pkg::t_pp     r_s2_pp_lo [mcfd_pkg::N_LANES];
    mcfd_pkg::t_pp     r_s2_pp_hi [mcfd_pkg::N_LANES];
    mcfd_pkg::t_pp     n_s2_pp_lo [mcfd_pkg::N_LANES];
    mcfd_pkg::t_pp     n_s2_pp_hi [mcfd_pkg::N_LANES];

    always_comb begin
        for (int l = 0; l < mcfd_pkg::N_LANES; l++) begin
            n_s2_pp_lo[l] = mcfd_pkg::t_pp'(r_s1_mag[l]) * mcfd_pkg::t_pp'(
                M_TBL[l][r_s1_slot][mcfd_pkg::MULT_SPLIT-1:0]);
            n_s2_pp_hi[l] = mcfd_pkg::t_pp'(r_s1_mag[l]) * mcfd_pkg::t_pp'(
                M_TBL[l][r_s1_slot][mcfd_pkg::MULT_W-1:mcfd_pkg::MULT_SPLIT]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: join the partial products, add the rounding half and take
    // the quotient at the slot's shift.
    // ------------------------------------------------------------------
    logic              r_s3_valid;
    mcfd_pkg::t_status r_s3_status;
    logic [2:0]        r_s3_slot;
    logic              r_s3_neg [mcfd_pkg::N_LANES];
    mcfd_pkg::t_q      r_s3_q [mcfd_pkg::N_LANES];
    mcfd_pkg::t_q      n_s3_q [mcfd_pkg::N_LANES];
    mcfd_pkg::t_sum    s3_sum [mcfd_pkg::N_LANES];
    logic              s2_fx;

    always_comb begin
        // Slots six and seven share the int16 scaling
        s2_fx = r_s2_slot[2] & r_s2_slot[1];
        for (int l = 0; l < mcfd_pkg::N_LANES; l++) begin
            if (s2_fx) begin
                s3_sum[l] = (mcfd_pkg::t_sum'(r_s2_pp_hi[l]) << mcfd_pkg::MULT_SPLIT)
                          + mcfd_pkg::t_sum'(r_s2_pp_lo[l])
                          + (mcfd_pkg::t_sum'(1) << (SH_FX[l] - 1));
                n_s3_q[l] = mcfd_pkg::t_q'(s3_sum[l] >> SH_FX[l]);
            end else begin
                s3_sum[l] = (mcfd_pkg::t_sum'(r_s2_pp_hi[l]) << mcfd_pkg::MULT_SPLIT)
                          + mcfd_pkg::t_sum'(r_s2_pp_lo[l])
                          + (mcfd_pkg::t_sum'(1) << (SH_PK[l] - 1));
                n_s3_q[l] = mcfd_pkg::t_q'(s3_sum[l] >> SH_PK[l]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: saturate, apply the sign, zero the values of frames that
    // were not decoded, and present the beat for one cycle.
    // ------------------------------------------------------------------
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [2:0]        r_out_slot;
    logic [31:0]       r_out_val [mcfd_pkg::N_LANES];
    logic [31:0]       n_out_val [mcfd_pkg::N_LANES];
    logic              s3_decoded;

    always_comb begin
        s3_decoded = (r_s3_status == mcfd_pkg::ST_PACKED) ||
                     (r_s3_status == mcfd_pkg::ST_INT16);
        for (int l = 0; l < mcfd_pkg::N_LANES; l++) begin
            if (!s3_decoded) begin
                n_out_val[l] = 32'd0;
            end else if (r_s3_neg[l]) begin
                n_out_val[l] = (r_s3_q[l] > 34'h080000000) ? 32'h80000000
                                                           : 32'd0 - r_s3_q[l][31:0];
            end else begin
                n_out_val[l] = (r_s3_q[l] > 34'h07FFFFFFF) ? 32'h7FFFFFFF
                                                           : r_s3_q[l][31:0];
            end
        end
    end

    // Valid bits: cleared by reset, advance every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // Payload: load every cycle, the valid bits mark which stages hold a beat
    always_ff @(posedge i_clk) begin
        r_s1_status  <= n_s1_status;
        r_s1_slot    <= n_s1_slot;
        r_s2_status  <= r_s1_status;
        r_s2_slot    <= r_s1_slot;
        r_s3_status  <= r_s2_status;
        r_s3_slot    <= r_s2_slot;
        r_out_status <= r_s3_status;
        r_out_slot   <= r_s3_slot;
        for (int l = 0; l < mcfd_pkg::N_LANES; l++) begin
            r_s1_neg[l]   <= n_s1_neg[l];
            r_s1_mag[l]   <= n_s1_mag[l];
            r_s2_neg[l]   <= r_s1_neg[l];
            r_s2_pp_lo[l] <= n_s2_pp_lo[l];
            r_s2_pp_hi[l] <= n_s2_pp_hi[l];
            r_s3_neg[l]   <= r_s2_neg[l];
            r_s3_q[l]     <= n_s3_q[l];
            r_out_val[l]  <= n_out_val[l];
        end
    end

    assign o_strobe         = r_out_valid;
    assign o_status         = r_out_status;
    assign o_motor_slot     = r_out_slot;
    assign o_position_rad   = r_out_val[mcfd_pkg::LANE_POS];
    assign o_velocity_rad_s = r_out_val[mcfd_pkg::LANE_VEL];
    assign o_torque_nm      = r_out_val[mcfd_pkg::LANE_TOR];

`ifndef SYNTH
    // Every accepted beat leaves under o_strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("accepted beat did not emerge after four cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 4))
        else $error("result strobe without a matching accepted beat");

    // Frames that were not decoded carry zero values; unknown ids carry slot zero
    a_undecoded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == mcfd_pkg::ST_UNKNOWN || o_status == mcfd_pkg::ST_SHORT))
        |-> (o_position_rad == 32'sd0 && o_velocity_rad_s == 32'sd0 && o_torque_nm == 32'sd0
             && (o_status == mcfd_pkg::ST_SHORT || o_motor_slot == mcfd_pkg::SLOT_NONE)))
        else $error("undecoded frame with nonzero values or slot");

    a_int16_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == mcfd_pkg::ST_INT16) |-> (o_motor_slot[2:1] == 2'b11))
        else $error("int16 result outside slots six and seven");
`endif

endmodule
